// ===== hdl/wms_pkg.sv =====
// Shared types, constants and codes for the wildcard match scorer.
// No dependencies; every other file of the block but wms_ram imports this package.
package wms_pkg;

	localparam int LEN_BITS        = 7;
	localparam int SYM_FIELD_BITS  = 8;
	localparam int POS_BITS        = 32;
	localparam int SCORE_BITS      = 38;
	localparam int DEF_MAX_PATTERN = 64;
	localparam int DEF_SYMBOL_BITS = 8;

	localparam int APB_DATA_BITS = 32;
	localparam int PADDR_BITS    = 3;
	localparam int REG_ADDR_LSB  = 2;

	typedef enum logic [PADDR_BITS-REG_ADDR_LSB-1:0] {
		REG_PATTERN_LENGTH = 1'b0
	} reg_index_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TEXT = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic                      command;
		logic [SYM_FIELD_BITS-1:0] symbol;
	} in_item_t;

	typedef struct packed {
		logic [POS_BITS-1:0]   alignment_start;
		logic [SCORE_BITS-1:0] score;
		logic                  is_match;
	} out_item_t;

	// per-cycle control of the window row
	typedef struct packed {
		logic shift;
		logic scan;
	} cell_ctrl_t;

	// tag that rides along with each term through the multiplier pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} pipe_ctrl_t;

endpackage

// ===== hdl/wildcard_match_scorer.sv =====
// Wildcard match scorer. A text transfer that completes an alignment of L symbols
// (L = effective pattern length) stalls the item channel until its result is pushed
// into the result register: the row walks one pattern position per cycle past
// the pattern RAM read port and the term multiplier. Load transfers and text
// transfers that leave the window short do not stall. Reset clears control, the
// window and the counters; pattern RAM holds garbage until loaded, with no sweep.
module wildcard_match_scorer import wms_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// item channel
	input  logic                     item_valid,
	output logic                     item_stall,
	input  in_item_t                 item,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output out_item_t                result,
	// register port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_BITS-1:0]    paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	// AW indexes the pattern store, LW counts up to MAX_PATTERN,
	// CW is wide enough for both that count and the length register
	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int CW = (LW > LEN_BITS) ? LW : LEN_BITS;
	localparam int TW = 4 * SYMBOL_BITS;

	state_t                 state_q, state_d;
	logic                   scan_en;
	logic                   push;

	logic [LEN_BITS-1:0]    len_q;
	logic                   cfg_wr;
	logic                   len_wr;
	logic [CW-1:0]          len_raw;
	logic [CW-1:0]          len_eff;

	logic                   item_xfer;
	logic                   text_xfer;
	logic                   load_xfer;
	logic [SYMBOL_BITS-1:0] sym;

	logic [AW-1:0]          lp_q;
	logic [AW-1:0]          ptr_cur;
	logic [CW-1:0]          ptr_inc;
	logic [AW-1:0]          lp_nxt;

	logic [LW-1:0]          fill_q;
	logic [LW-1:0]          fill_inc;
	logic                   full;

	logic [POS_BITS-1:0]    pos_q;
	logic [POS_BITS-1:0]    align_q;
	logic [AW-1:0]          addr_q;

	cell_ctrl_t             row_ctrl;
	logic [SYMBOL_BITS-1:0] win   [MAX_PATTERN];
	logic [SYMBOL_BITS-1:0] work  [MAX_PATTERN];

	logic [SYMBOL_BITS-1:0] p_s1;
	logic [SYMBOL_BITS-1:0] t_s1;
	pipe_ctrl_t             ctrl_s1;
	pipe_ctrl_t             ctrl_s3;
	logic [TW-1:0]          term_s3;
	logic                   nz_s3;

	logic [SCORE_BITS-1:0]  acc_q;
	logic                   allz_q;
	out_item_t              res_q;
	logic                   res_valid_q;

	// ---------------------------------------------------------------
	// Register port: one length register, always ready
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		len_wr = 1'b0;
		prdata = '0;
		case (reg_index_t'(paddr[PADDR_BITS-1:REG_ADDR_LSB]))
			REG_PATTERN_LENGTH: begin
				len_wr = cfg_wr;
				prdata = APB_DATA_BITS'(len_q);
			end
			default: begin
				len_wr = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_BITS'(1);
		end else if (len_wr) begin
			len_q <= pwdata[LEN_BITS-1:0];
		end
	end

	// clamp to 1..MAX_PATTERN: zero acts as one, oversize as the full row
	assign len_raw = CW'(len_q);
	assign len_eff = (len_raw == '0) ? CW'(1) :
	                 (len_raw > CW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : len_raw;

	// ---------------------------------------------------------------
	// Item decode
	// ---------------------------------------------------------------
	assign item_xfer = item_valid && !item_stall;
	assign text_xfer = item_xfer && (item.command == CMD_TEXT);
	assign load_xfer = item_xfer && (item.command == CMD_LOAD);
	assign sym       = SYMBOL_BITS'(item.symbol);

	// Load pointer restarts at 0 when a shorter length left it out of range,
	// and wraps after the last pattern position so the next load starts over.
	assign ptr_cur = (CW'(lp_q) >= len_eff) ? '0 : lp_q;
	assign ptr_inc = CW'(ptr_cur) + CW'(1);
	assign lp_nxt  = (ptr_inc >= len_eff) ? '0 : AW'(ptr_inc);

	// Window fill saturates at the row length.
	assign fill_inc = (fill_q == LW'(MAX_PATTERN)) ? fill_q : fill_q + LW'(1);
	assign full     = CW'(fill_inc) >= len_eff;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		scan_en = 1'b0;
		push    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (text_xfer && full) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// walk the pattern from its last position down to 0
				scan_en = 1'b1;
				if (addr_q == '0) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (ctrl_s3.valid && ctrl_s3.last) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				// hold the sum until the result register is free
				if (!res_valid_q || !result_stall) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign item_stall = (state_q != ST_IDLE);

	// ---------------------------------------------------------------
	// Counters and positions
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q   <= '0;
			fill_q <= '0;
			pos_q  <= '0;
			addr_q <= '0;
		end else begin
			if (load_xfer) begin
				lp_q <= lp_nxt;
			end
			if (text_xfer) begin
				fill_q <= fill_inc;
				pos_q  <= pos_q + POS_BITS'(1);
			end
			if (text_xfer && full) begin
				addr_q <= AW'(len_eff - CW'(1));
			end else if (scan_en) begin
				addr_q <= addr_q - AW'(1);
			end
		end
	end

	// first text position of the alignment that ends at this transfer
	always_ff @(posedge clk) begin
		if (text_xfer) begin
			align_q <= pos_q + POS_BITS'(1) - POS_BITS'(len_eff);
		end
	end

	// ---------------------------------------------------------------
	// Pattern store
	// ---------------------------------------------------------------
	wms_ram #(
		.WIDTH (SYMBOL_BITS),
		.DEPTH (MAX_PATTERN)
	) u_pattern_ram (
		.clk   (clk),
		.we    (load_xfer),
		.waddr (ptr_cur),
		.wdata (sym),
		.re    (scan_en),
		.raddr (addr_q),
		.rdata (p_s1)
	);

	// ---------------------------------------------------------------
	// Window row: position 0 holds the newest symbol. On a text transfer every
	// position takes its neighbor's symbol and copies the new window into its
	// scan register; during the scan the copies move toward position 0, so
	// position 0 shows window[c] while the RAM reads pattern[L-1-c].
	// ---------------------------------------------------------------
	assign row_ctrl.shift = text_xfer;
	assign row_ctrl.scan  = scan_en;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_row
		logic [SYMBOL_BITS-1:0] window_in;
		logic [SYMBOL_BITS-1:0] work_in;

		if (j == 0) begin : g_head
			assign window_in = sym;
		end else begin : g_body
			assign window_in = win[j-1];
		end

		if (j == MAX_PATTERN - 1) begin : g_tail
			assign work_in = '0;
		end else begin : g_link
			assign work_in = work[j+1];
		end

		wms_cell #(
			.SYMBOL_BITS (SYMBOL_BITS)
		) u_pos (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (row_ctrl),
			.window_in  (window_in),
			.work_in    (work_in),
			.window_out (win[j]),
			.work_out   (work[j])
		);
	end

	// ---------------------------------------------------------------
	// Term pipeline: stage 1 lines the text tap up with the RAM read data
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= scan_en;
			ctrl_s1.last  <= scan_en && (addr_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (scan_en) begin
			t_s1 <= work[0];
		end
	end

	wms_term #(
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_term (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_s1 (ctrl_s1),
		.p_s1    (p_s1),
		.t_s1    (t_s1),
		.ctrl_s3 (ctrl_s3),
		.term_s3 (term_s3),
		.nz_s3   (nz_s3)
	);

	// Accumulate modulo 2^38; the match flag comes from the terms themselves
	// so it stays exact even when the sum wraps.
	always_ff @(posedge clk) begin
		if (text_xfer) begin
			acc_q  <= '0;
			allz_q <= 1'b1;
		end else if (ctrl_s3.valid) begin
			acc_q  <= acc_q + SCORE_BITS'(term_s3);
			allz_q <= allz_q && !nz_s3;
		end
	end

	// ---------------------------------------------------------------
	// Result register: frees the item side while a result waits
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q.alignment_start <= align_q;
			res_q.score           <= acc_q;
			res_q.is_match        <= allz_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== hdl/wms_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the pattern store.
module wms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/wms_cell.sv =====
// One position of the text window row: the live window symbol and a scan copy.
// Depends on wms_pkg for the row control struct.
module wms_cell import wms_pkg::*; #(
	parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_ctrl_t             ctrl,
	input  logic [SYMBOL_BITS-1:0] window_in,
	input  logic [SYMBOL_BITS-1:0] work_in,
	output logic [SYMBOL_BITS-1:0] window_out,
	output logic [SYMBOL_BITS-1:0] work_out
);

	logic [SYMBOL_BITS-1:0] window_q;
	logic [SYMBOL_BITS-1:0] work_q;

	// window advances one place per text transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (ctrl.shift) begin
			window_q <= window_in;
		end
	end

	// scan copy: snapshot of the new window, then walk toward position 0
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			work_q <= window_in;
		end else if (ctrl.scan) begin
			work_q <= work_in;
		end
	end

	assign window_out = window_q;
	assign work_out   = work_q;

endmodule

// ===== hdl/wms_term.sv =====
// Two-stage pipeline for one term p*t*(p-t)^2 and its nonzero flag.
// Depends on wms_pkg for the pipeline tag struct.
module wms_term import wms_pkg::*; #(
	parameter int SYMBOL_BITS = DEF_SYMBOL_BITS,
	localparam int PW = 2 * SYMBOL_BITS,
	localparam int TW = 4 * SYMBOL_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pipe_ctrl_t             ctrl_s1,
	input  logic [SYMBOL_BITS-1:0] p_s1,
	input  logic [SYMBOL_BITS-1:0] t_s1,
	output pipe_ctrl_t             ctrl_s3,
	output logic [TW-1:0]          term_s3,
	output logic                   nz_s3
);

	logic [SYMBOL_BITS-1:0] diff;
	pipe_ctrl_t             ctrl_s2;
	logic [PW-1:0]          pt_s2;
	logic [PW-1:0]          dd_s2;
	logic                   nz_s2;
	pipe_ctrl_t             ctrl_s3_q;
	logic [TW-1:0]          term_s3_q;
	logic                   nz_s3_q;

	assign diff = (p_s1 >= t_s1) ? (p_s1 - t_s1) : (t_s1 - p_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2   <= '0;
			ctrl_s3_q <= '0;
		end else begin
			ctrl_s2   <= ctrl_s1;
			ctrl_s3_q <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		pt_s2     <= PW'(p_s1) * PW'(t_s1);
		dd_s2     <= PW'(diff) * PW'(diff);
		nz_s2     <= (p_s1 != '0) && (t_s1 != '0) && (p_s1 != t_s1);
		term_s3_q <= TW'(pt_s2) * TW'(dd_s2);
		nz_s3_q   <= nz_s2;
	end

	assign ctrl_s3 = ctrl_s3_q;
	assign term_s3 = term_s3_q;
	assign nz_s3   = nz_s3_q;

endmodule

// ===== hdl/wms_checker.sv =====
// Port-level checks for the wildcard match scorer, bound onto the top level.
// Depends on wms_pkg and on the top level's port names.
module wms_checker import wms_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_valid,
	input logic                     item_stall,
	input logic                     result_valid,
	input logic                     result_stall,
	input out_item_t                result,
	input logic                     psel,
	input logic                     penable,
	input logic                     pwrite,
	input logic [PADDR_BITS-1:0]    paddr,
	input logic [APB_DATA_BITS-1:0] pwdata,
	input logic [APB_DATA_BITS-1:0] prdata,
	input logic                     pready
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// a reported match must carry a zero score
	a_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_match |-> result.score == '0)
		else $error("match reported with nonzero score");

	// an item transfer never produces a result in the very next cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !result_valid |=> !result_valid)
		else $error("result appeared one cycle after an item transfer");

	// the length register reads back what was written
	a_len_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready &&
		paddr[PADDR_BITS-1:REG_ADDR_LSB] == REG_PATTERN_LENGTH
		|=> prdata[LEN_BITS-1:0] == $past(pwdata[LEN_BITS-1:0]))
		else $error("length register readback mismatch");

endmodule

bind wildcard_match_scorer wms_checker u_wms_checker (.*);

// ===== verif/wms_score_checker.sv =====
// Scoreboard for the wildcard match scorer: follows register writes, item and result transfers.
// Keeps its own copy of pattern, text window and counters, predicts each score and compares it.
// Depends on wms_pkg for the payload structs, the command codes and the register index.
module wms_score_checker import wms_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  logic                     item_stall,
	input  in_item_t                 item,
	input  logic                     result_valid,
	input  logic                     result_stall,
	input  out_item_t                result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [PADDR_BITS-1:0]    paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output int unsigned              scores_awaited,
	output int unsigned              mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_P = DEF_MAX_PATTERN;

	logic [SYM_FIELD_BITS-1:0] pattern_copy [MAX_P];
	logic [SYM_FIELD_BITS-1:0] window_copy [MAX_P];
	int unsigned               load_slot;
	int unsigned               fill_count;
	logic [POS_BITS-1:0]       text_count;
	logic [LEN_BITS-1:0]       length_reg;
	out_item_t                 awaited_scores [$];
	int unsigned               mismatch_count = 0;

	assign mismatches = mismatch_count;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t           want;
		int unsigned         span;
		int                  j;
		logic [63:0]         p, t, d, term, sum;
		logic                exact;
		logic [POS_BITS-1:0] pos;
		if (!arst_n) begin
			for (j = 0; j < MAX_P; j++) begin
				pattern_copy[j] = '0;
				window_copy[j] = '0;
			end
			load_slot = 0;
			fill_count = 0;
			text_count = '0;
			length_reg = LEN_BITS'(1);
			awaited_scores.delete();
			scores_awaited <= 0;
		end else begin
			// clamp the length: zero acts as one, anything past the store depth as the depth
			if (length_reg == 0)
				span = 1;
			else if (length_reg > MAX_P)
				span = MAX_P;
			else
				span = length_reg;

			if (result_valid && !result_stall) begin
				if (awaited_scores.size() == 0) begin
					report_mismatch($sformatf("result with nothing awaited: start %0d score %0d match %0b",
						result.alignment_start, result.score, result.is_match));
				end else begin
					want = awaited_scores.pop_front();
					if (result.alignment_start !== want.alignment_start)
						report_mismatch($sformatf("alignment_start got %0d want %0d",
							result.alignment_start, want.alignment_start));
					if (result.score !== want.score)
						report_mismatch($sformatf("score at %0d got %0d want %0d",
							want.alignment_start, result.score, want.score));
					if (result.is_match !== want.is_match)
						report_mismatch($sformatf("is_match at %0d got %0b want %0b",
							want.alignment_start, result.is_match, want.is_match));
				end
			end

			if (item_valid && !item_stall) begin
				if (item.command == CMD_LOAD) begin
					if (load_slot >= span)
						load_slot = 0;
					pattern_copy[load_slot] = item.symbol;
					load_slot++;
					if (load_slot >= span)
						load_slot = 0;
				end else begin
					for (j = MAX_P - 1; j > 0; j--)
						window_copy[j] = window_copy[j-1];
					window_copy[0] = item.symbol;
					if (fill_count < MAX_P)
						fill_count++;
					pos = text_count;
					text_count = text_count + 1'b1;
					if (fill_count >= span) begin
						sum = '0;
						exact = 1'b1;
						for (j = 0; j < span; j++) begin
							p = 64'(pattern_copy[j]);
							t = 64'(window_copy[span-1-j]);
							d = (p >= t) ? p - t : t - p;
							term = p * t * d * d;
							if (term != 0)
								exact = 1'b0;
							sum = sum + term;
						end
						want.alignment_start = pos + POS_BITS'(1) - POS_BITS'(span);
						want.score = sum[SCORE_BITS-1:0];
						want.is_match = exact;
						awaited_scores.push_back(want);
					end
				end
			end

			if (psel && penable && pwrite && pready &&
				paddr[PADDR_BITS-1:REG_ADDR_LSB] == REG_PATTERN_LENGTH)
				length_reg = pwdata[LEN_BITS-1:0];

			scores_awaited <= awaited_scores.size();
		end
	end

endmodule

// ===== verif/tb_wildcard_match_scorer.sv =====
// Testbench top for the wildcard match scorer: clock, reset, stimulus, result stalls, verdict.
// Depends on wms_pkg, the wildcard_match_scorer RTL and the wms_score_checker scoreboard.
module tb_wildcard_match_scorer import wms_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RANDOM_ITEMS  = 550;
	// room for a full-length alignment to finish, padded
	localparam int          SETTLE_CYCLES = DEF_MAX_PATTERN + 16;
	localparam int unsigned CYCLE_LIMIT   = 800_000;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	in_item_t                 item = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	out_item_t                result;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [PADDR_BITS-1:0]    paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int unsigned scores_awaited;
	int unsigned mismatches;
	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;
	// calm stretches: no sender gaps and no receiver stalls
	logic        calm = 1'b0;

	// mirror of the pattern as the stimulus loaded it, used to plant alignments
	logic [SYM_FIELD_BITS-1:0] loaded_pattern [DEF_MAX_PATTERN];
	int unsigned               next_slot = 0;
	int unsigned               active_span = 1;

	wildcard_match_scorer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	wms_score_checker u_score_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.scores_awaited (scores_awaited),
		.mismatches     (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: end the run if the stream hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: after each result transfer draw a stall for the next one and
	// count it down only while a result is actually offered.
	always @(posedge clk or negedge arst_n) begin : result_drain
		int unsigned hold_cycles;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (result_valid) begin
			if (!result_stall) begin
				hold_cycles = calm ? 0 : $urandom_range(0, 19);
				stall_left <= hold_cycles;
				result_stall <= (hold_cycles != 0);
			end else begin
				stall_left <= stall_left - 1;
				result_stall <= (stall_left > 1);
			end
		end
	end

	// Wildcards, a tiny alphabet for near coincidences, the top value, or anything.
	function automatic logic [SYM_FIELD_BITS-1:0] pick_symbol();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return '0;
		else if (r < 6)
			return SYM_FIELD_BITS'($urandom_range(1, 3));
		else if (r == 6)
			return '1;
		return SYM_FIELD_BITS'($urandom_range(0, 255));
	endfunction

	// Offer one item after a random gap and hold it until the transfer. Valid stays
	// high afterwards so a back-to-back item keeps the channel busy.
	task automatic send_item(input command_t cmd, input logic [SYM_FIELD_BITS-1:0] sym);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{command: cmd, symbol: sym};
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (cmd == CMD_LOAD) begin
			// track the load pointer the same way the block advances it
			if (next_slot >= active_span)
				next_slot = 0;
			loaded_pattern[next_slot] = sym;
			next_slot++;
			if (next_slot >= active_span)
				next_slot = 0;
		end
	endtask

	// Drop valid, wait for every awaited score, then let the pipe drain.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (scores_awaited != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, access cycle, complete on pready.
	task automatic write_length(input logic [LEN_BITS-1:0] raw);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_BITS'(REG_PATTERN_LENGTH) << REG_ADDR_LSB;
		pwdata <= APB_DATA_BITS'(raw);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (raw == 0)
			active_span = 1;
		else if (raw > DEF_MAX_PATTERN)
			active_span = DEF_MAX_PATTERN;
		else
			active_span = raw;
	endtask

	initial begin : stimulus
		logic [LEN_BITS-1:0]       extremes [6];
		logic [LEN_BITS-1:0]       raw;
		logic [SYM_FIELD_BITS-1:0] sym;
		int unsigned               random_items;
		int unsigned               phase;
		int unsigned               stop_at;
		int unsigned               choice;
		int unsigned               count;
		int unsigned               r;

		extremes = '{7'd127, 7'd64, 7'd0, 7'd1, 7'd65, 7'd2};

		// Hold reset, then release it on a clock edge.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset length of one, a wildcard text symbol, the top value.
		send_item(CMD_LOAD, 8'd200);
		send_item(CMD_TEXT, 8'd0);
		send_item(CMD_TEXT, 8'd255);

		// Length four with a wildcard inside the pattern; the window is still
		// short for the first text symbol, then a planted match closes the run.
		settle();
		write_length(7'd4);
		send_item(CMD_LOAD, 8'd255);
		send_item(CMD_LOAD, 8'd0);
		send_item(CMD_LOAD, 8'd1);
		send_item(CMD_LOAD, 8'd128);
		send_item(CMD_TEXT, 8'd1);
		send_item(CMD_TEXT, 8'd255);
		send_item(CMD_TEXT, 8'd7);
		send_item(CMD_TEXT, 8'd1);
		send_item(CMD_TEXT, 8'd128);
		send_item(CMD_TEXT, 8'd255);
		send_item(CMD_TEXT, 8'd9);
		send_item(CMD_TEXT, 8'd1);
		send_item(CMD_TEXT, 8'd128);

		// Length zero behaves as one; an all-wildcard pattern matches anything.
		settle();
		write_length(7'd0);
		send_item(CMD_LOAD, 8'd0);
		send_item(CMD_TEXT, 8'd255);
		send_item(CMD_TEXT, 8'd1);

		// Random phases: each picks a length, loads a full pattern first so no
		// unwritten entry is ever scored, then mixes planted alignments, loose
		// text, partial reloads and full drains.
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			if (phase < 6)
				raw = extremes[phase];
			else if ($urandom_range(0, 4) == 0)
				raw = LEN_BITS'($urandom_range(0, 127));
			else
				raw = LEN_BITS'($urandom_range(1, 10));
			write_length(raw);
			calm <= ($urandom_range(0, 3) == 0);

			for (int k = 0; k < active_span; k++)
				send_item(CMD_LOAD, pick_symbol());
			random_items += active_span;

			stop_at = random_items + active_span + $urandom_range(20, 50);
			while (random_items < stop_at) begin
				choice = $urandom_range(0, 99);
				if (choice < 55) begin
					// plant the pattern; occasionally wildcard or disturb a symbol
					for (int k = 0; k < active_span; k++) begin
						sym = loaded_pattern[k];
						r = $urandom_range(0, 9);
						if (r == 0)
							sym = '0;
						else if (r == 1)
							sym = pick_symbol();
						send_item(CMD_TEXT, sym);
					end
					random_items += active_span;
				end else if (choice < 85) begin
					count = $urandom_range(1, 6);
					repeat (count) send_item(CMD_TEXT, pick_symbol());
					random_items += count;
				end else if (choice < 95) begin
					// partial reload leaves the load pointer mid-pattern
					count = $urandom_range(1, active_span);
					repeat (count) send_item(CMD_LOAD, pick_symbol());
					random_items += count;
				end else begin
					// hold off until every awaited score has come back
					item_valid <= 1'b0;
					@(posedge clk);
					while (scores_awaited != 0) @(posedge clk);
				end
			end
			phase++;
		end

		settle();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
